>>> rtl/core/bisf_pkg.sv
// bisf_pkg: shared types, codes and sizes of the boot image section framer
// depends on nothing; imported by every module under rtl/core
`timescale 1ns / 1ps

package bisf_pkg;

    // result queue sizing
    localparam int RQ_DEPTH  = 8;
    localparam int RQ_PTR_W  = 3;
    localparam int RQ_CNT_W  = 4;
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = 2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_START   = 2'd0;
    localparam t_mode MODE_SEGMENT = 2'd1;
    localparam t_mode MODE_DATA    = 2'd2;
    localparam t_mode MODE_FINISH  = 2'd3;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_HEADER   = 3'd0;
    localparam t_kind KIND_SEC_LEN  = 3'd1;
    localparam t_kind KIND_SEC_ADDR = 3'd2;
    localparam t_kind KIND_PAYLOAD  = 3'd3;
    localparam t_kind KIND_END_LEN  = 3'd4;
    localparam t_kind KIND_ENTRY    = 3'd5;
    localparam t_kind KIND_CHECKSUM = 3'd6;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_SEG   = 2'd1;
    localparam t_status ST_TOO_MANY = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IMAGE_CONTROL  = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_KIND     = 2'd1;
    localparam t_cfg_idx CFG_RETAIN_VECTORS = 2'd2;

    typedef logic [4:0] t_seg_cnt;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] seg_address;
        logic [31:0] seg_mem_bytes;
        logic [31:0] seg_file_bytes;
        logic [31:0] data_word;
        logic [31:0] entry_point;
    } t_item;

    typedef struct packed {
        logic [7:0] image_control;
        logic [7:0] image_kind;
        logic       retain_vectors;
    } t_cfg;

    typedef struct packed {
        logic [31:0] running_sum;
        logic [31:0] section_address;
        logic [31:0] segment_bytes_left;
        logic [31:0] section_bytes_left;
        logic [31:0] file_bytes_left;
        logic [31:0] skip_bytes_left;
        t_seg_cnt    segments_seen;
        t_seg_cnt    segments_kept;
        logic        too_many;
    } t_state;

    typedef struct packed {
        logic [31:0] out_word;
        t_kind       word_kind;
        logic        last;
        t_status     status;
    } t_result;

    // trimmed segment as seen by the sequencer
    typedef struct packed {
        logic        dropped;
        logic [31:0] section_address;
        logic [31:0] segment_bytes;
        logic [31:0] file_bytes;
        logic [31:0] skip_bytes;
    } t_seg_plan;

    // result queue control and status
    typedef struct packed {
        logic [RES_CNT_W-1:0] push_cnt;
        logic                 pop;
    } t_rq_ctl;

    typedef struct packed {
        logic                not_empty;
        logic                room;
        logic [RQ_CNT_W-1:0] count;
    } t_rq_stat;

endpackage

>>> rtl/core/bisf_seg_calc.sv
// bisf_seg_calc: trims a segment descriptor against the vector area and rounds it to words
// depends on bisf_pkg
`timescale 1ns / 1ps

module bisf_seg_calc import bisf_pkg::*; #(
    parameter int VECTOR_AREA_END = 256
) (
    input  logic [31:0] i_address,
    input  logic [31:0] i_mem_bytes,
    input  logic [31:0] i_file_bytes,
    input  logic        i_retain_vectors,
    output t_seg_plan   o_plan
);

    localparam logic [31:0] VEC_END = 32'(VECTOR_AREA_END);

    // round up to whole words, saturating at the last word
    function automatic logic [31:0] words_up(input logic [31:0] n);
        logic [29:0] q;
        logic [31:0] r;
        q = n[31:2] + 30'd1;
        if (n[1:0] == 2'd0) begin
            r = n;
        end else if (&n[31:2]) begin
            r = 32'hFFFF_FFFC;
        end else begin
            r = {q, 2'b00};
        end
        return r;
    endfunction

    logic [31:0] file_clamped;
    logic [31:0] skip;
    logic [31:0] mem_trim;
    logic [31:0] file_trim;
    logic [31:0] rounded;
    logic        in_vec;
    logic        drop;

    always_comb begin
        file_clamped = (i_file_bytes > i_mem_bytes) ? i_mem_bytes : i_file_bytes;
        in_vec       = !i_retain_vectors && (i_address < VEC_END);
        skip         = VEC_END - i_address;
        drop         = in_vec && (skip >= i_mem_bytes);
        mem_trim     = in_vec ? (i_mem_bytes - skip) : i_mem_bytes;
        if (!in_vec) begin
            file_trim = file_clamped;
        end else if (file_clamped > skip) begin
            file_trim = file_clamped - skip;
        end else begin
            file_trim = 32'd0;
        end
        // a dropped segment consumes its whole rounded size as skipped words
        rounded = words_up(drop ? i_mem_bytes : mem_trim);

        o_plan.dropped         = drop;
        o_plan.section_address = in_vec ? VEC_END : i_address;
        o_plan.segment_bytes   = rounded;
        o_plan.file_bytes      = file_trim;
        if (drop) begin
            o_plan.skip_bytes = rounded;
        end else if (in_vec) begin
            o_plan.skip_bytes = skip;
        end else begin
            o_plan.skip_bytes = 32'd0;
        end
    end

endmodule

>>> rtl/core/bisf_step.sv
// bisf_step: next framer state and the up to three result words of one item
// depends on bisf_pkg and bisf_seg_calc
`timescale 1ns / 1ps

module bisf_step import bisf_pkg::*; #(
    parameter int MAX_SECTION_BYTES = 32768,
    parameter int VECTOR_AREA_END   = 256,
    parameter int MAX_SEGMENTS      = 16,
    parameter int SIGNATURE_LOW     = 67,
    parameter int SIGNATURE_HIGH    = 89
) (
    input  t_state               i_state,
    input  t_cfg                 i_cfg,
    input  t_item                i_item,
    output t_state               o_state,
    output t_result              o_res [MAX_RES],
    output logic [RES_CNT_W-1:0] o_res_cnt
);

    localparam int          SEC_ROUND   = MAX_SECTION_BYTES / 4 * 4;
    localparam int          SEC_LIMIT_I = (SEC_ROUND < 4) ? 4 : SEC_ROUND;
    localparam logic [31:0] SEC_LIMIT   = 32'(SEC_LIMIT_I);
    localparam t_seg_cnt    SEG_MAX     = 5'(MAX_SEGMENTS);
    localparam logic [15:0] SIG_WORD    = {8'(SIGNATURE_HIGH), 8'(SIGNATURE_LOW)};

    t_seg_plan plan;

    bisf_seg_calc #(
        .VECTOR_AREA_END(VECTOR_AREA_END)
    ) u_seg_calc (
        .i_address        (i_item.seg_address),
        .i_mem_bytes      (i_item.seg_mem_bytes),
        .i_file_bytes     (i_item.seg_file_bytes),
        .i_retain_vectors (i_cfg.retain_vectors),
        .o_plan           (plan)
    );

    always_comb begin
        logic [31:0] chunk;
        logic [31:0] w_eff;
        logic [31:0] sect_base;
        logic        opens;

        o_state   = i_state;
        o_res_cnt = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            o_res[k] = '0;
        end
        chunk     = (i_state.segment_bytes_left > SEC_LIMIT) ? SEC_LIMIT
                                                             : i_state.segment_bytes_left;
        opens     = (i_state.section_bytes_left == 32'd0);
        sect_base = opens ? chunk : i_state.section_bytes_left;
        // zero the bytes past the end of file data
        if (i_state.file_bytes_left >= 32'd4) begin
            w_eff = i_item.data_word;
        end else begin
            case (i_state.file_bytes_left[1:0])
                2'd1:    w_eff = {24'd0, i_item.data_word[7:0]};
                2'd2:    w_eff = {16'd0, i_item.data_word[15:0]};
                2'd3:    w_eff = {8'd0, i_item.data_word[23:0]};
                default: w_eff = 32'd0;
            endcase
        end

        case (i_item.mode)
            MODE_START: begin
                o_state   = '0;
                o_res[0]  = '{out_word: {i_cfg.image_kind, i_cfg.image_control, SIG_WORD},
                              word_kind: KIND_HEADER, last: 1'b1, status: ST_OK};
                o_res_cnt = 2'd1;
            end
            MODE_SEGMENT: begin
                o_state.section_address    = '0;
                o_state.segment_bytes_left = '0;
                o_state.section_bytes_left = '0;
                o_state.file_bytes_left    = '0;
                o_state.skip_bytes_left    = '0;
                if (i_state.too_many || (i_state.segments_seen >= SEG_MAX)) begin
                    o_state.too_many = 1'b1;
                end else begin
                    o_state.segments_seen   = i_state.segments_seen + 5'd1;
                    o_state.skip_bytes_left = plan.skip_bytes;
                    if (!plan.dropped) begin
                        o_state.segments_kept      = i_state.segments_kept + 5'd1;
                        o_state.section_address    = plan.section_address;
                        o_state.segment_bytes_left = plan.segment_bytes;
                        o_state.file_bytes_left    = plan.file_bytes;
                    end
                end
            end
            MODE_DATA: begin
                if (i_state.skip_bytes_left != 32'd0) begin
                    o_state.skip_bytes_left = (i_state.skip_bytes_left > 32'd4)
                                            ? i_state.skip_bytes_left - 32'd4 : 32'd0;
                end else if (i_state.segment_bytes_left != 32'd0) begin
                    if (opens) begin
                        o_res[0] = '{out_word: {2'b00, chunk[31:2]}, word_kind: KIND_SEC_LEN,
                                     last: 1'b0, status: ST_OK};
                        o_res[1] = '{out_word: i_state.section_address,
                                     word_kind: KIND_SEC_ADDR, last: 1'b0, status: ST_OK};
                        o_res[2] = '{out_word: w_eff, word_kind: KIND_PAYLOAD,
                                     last: 1'b1, status: ST_OK};
                        o_res_cnt = 2'd3;
                    end else begin
                        o_res[0] = '{out_word: w_eff, word_kind: KIND_PAYLOAD,
                                     last: 1'b1, status: ST_OK};
                        o_res_cnt = 2'd1;
                    end
                    o_state.file_bytes_left    = (i_state.file_bytes_left >= 32'd4)
                                               ? i_state.file_bytes_left - 32'd4 : 32'd0;
                    o_state.running_sum        = i_state.running_sum + w_eff;
                    o_state.section_bytes_left = sect_base - 32'd4;
                    o_state.segment_bytes_left = i_state.segment_bytes_left - 32'd4;
                    o_state.section_address    = i_state.section_address + 32'd4;
                end
            end
            MODE_FINISH: begin
                o_state.section_address    = '0;
                o_state.segment_bytes_left = '0;
                o_state.section_bytes_left = '0;
                o_state.file_bytes_left    = '0;
                o_state.skip_bytes_left    = '0;
                if (i_state.too_many) begin
                    o_res[0]  = '{out_word: 32'd0, word_kind: KIND_CHECKSUM, last: 1'b1,
                                  status: ST_TOO_MANY};
                    o_res_cnt = 2'd1;
                end else if (i_state.segments_kept == 5'd0) begin
                    o_res[0]  = '{out_word: 32'd0, word_kind: KIND_CHECKSUM, last: 1'b1,
                                  status: ST_NO_SEG};
                    o_res_cnt = 2'd1;
                end else begin
                    o_res[0]  = '{out_word: 32'd0, word_kind: KIND_END_LEN, last: 1'b0,
                                  status: ST_OK};
                    o_res[1]  = '{out_word: i_item.entry_point, word_kind: KIND_ENTRY,
                                  last: 1'b0, status: ST_OK};
                    o_res[2]  = '{out_word: i_state.running_sum, word_kind: KIND_CHECKSUM,
                                  last: 1'b1, status: ST_OK};
                    o_res_cnt = 2'd3;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

>>> rtl/core/bisf_res_queue.sv
// bisf_res_queue: result queue taking up to three results a cycle and giving one
// depends on bisf_pkg
`timescale 1ns / 1ps

module bisf_res_queue import bisf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rq_ctl  i_ctl,
    input  t_result  i_res [MAX_RES],
    output t_rq_stat o_stat,
    output t_result  o_head
);

    t_result             r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr_ptr;
    logic [RQ_PTR_W-1:0] r_rd_ptr;
    logic [RQ_CNT_W-1:0] r_count;

    logic [RQ_PTR_W-1:0] n_wr_ptr;
    logic [RQ_PTR_W-1:0] n_rd_ptr;
    logic [RQ_CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + RQ_PTR_W'(i_ctl.push_cnt);
        n_rd_ptr = r_rd_ptr + RQ_PTR_W'(i_ctl.pop);
        n_count  = r_count + RQ_CNT_W'(i_ctl.push_cnt) - RQ_CNT_W'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (RES_CNT_W'(k) < i_ctl.push_cnt) begin
                r_mem[r_wr_ptr + RQ_PTR_W'(k)] <= i_res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_stat.not_empty = (r_count != '0);
    // room for a full three-result item
    assign o_stat.room      = (r_count <= RQ_CNT_W'(RQ_DEPTH - MAX_RES));
    assign o_stat.count     = r_count;
    assign o_head           = r_mem[r_rd_ptr];

endmodule

>>> rtl/core/boot_image_section_framer_core.sv
// boot_image_section_framer_core: top level of the boot image section framer
// depends on bisf_pkg, bisf_step (with bisf_seg_calc) and bisf_res_queue
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// ------    ---------  -------------------------  ----------------------------------------
// input     in         i_in_valid / o_in_stall    i_mode, i_seg_*, i_data_word, i_entry_point
// output    out        o_out_valid / i_out_stall  o_out_word, o_word_kind, o_last, o_status
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// one item is taken per cycle while o_in_stall is low; its state update and results are
// computed in the same cycle and the results land in an 8-entry result queue
// the output gives one result per cycle while i_out_stall is low, so section openers and
// successful finish items each put three results through it; the queue sets the rate
// stall on input rises while fewer than three queue entries are free
// an item's results are written into the queue as it is taken, behind any results still held
// synchronous active-low reset clears framer state and queue pointers, sets config defaults

module boot_image_section_framer_core import bisf_pkg::*; #(
    parameter int MAX_SECTION_BYTES = 32768,
    parameter int VECTOR_AREA_END   = 256,
    parameter int MAX_SEGMENTS      = 16,
    parameter int SIGNATURE_LOW     = 67,
    parameter int SIGNATURE_HIGH    = 89
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_mode       i_mode,
    input  logic [31:0] i_seg_address,
    input  logic [31:0] i_seg_mem_bytes,
    input  logic [31:0] i_seg_file_bytes,
    input  logic [31:0] i_data_word,
    input  logic [31:0] i_entry_point,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_out_word,
    output t_kind       o_word_kind,
    output logic        o_last,
    output t_status     o_status
);

    t_cfg                 r_cfg;
    t_state               r_state;
    t_state               n_state;
    t_item                item;
    t_result              step_res [MAX_RES];
    logic [RES_CNT_W-1:0] step_cnt;
    t_rq_ctl              rq_ctl;
    t_rq_stat             rq_stat;
    t_result              head;
    logic                 in_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_control  <= 8'd0;
            r_cfg.image_kind     <= 8'd176;
            r_cfg.retain_vectors <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_CONTROL:  r_cfg.image_control  <= i_cfg_data;
                CFG_IMAGE_KIND:     r_cfg.image_kind     <= i_cfg_data;
                CFG_RETAIN_VECTORS: r_cfg.retain_vectors <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign item = '{mode: i_mode, seg_address: i_seg_address,
                    seg_mem_bytes: i_seg_mem_bytes, seg_file_bytes: i_seg_file_bytes,
                    data_word: i_data_word, entry_point: i_entry_point};

    // all per-item work: trimming, sectioning, masking and checksum
    bisf_step #(
        .MAX_SECTION_BYTES (MAX_SECTION_BYTES),
        .VECTOR_AREA_END   (VECTOR_AREA_END),
        .MAX_SEGMENTS      (MAX_SEGMENTS),
        .SIGNATURE_LOW     (SIGNATURE_LOW),
        .SIGNATURE_HIGH    (SIGNATURE_HIGH)
    ) u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_item    (item),
        .o_state   (n_state),
        .o_res     (step_res),
        .o_res_cnt (step_cnt)
    );

    assign o_in_stall = !rq_stat.room;
    assign in_take    = i_in_valid && !o_in_stall;

    // framer state only moves on a taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    assign rq_ctl.push_cnt = in_take ? step_cnt : '0;
    assign rq_ctl.pop      = rq_stat.not_empty && !i_out_stall;

    bisf_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rq_ctl),
        .i_res   (step_res),
        .o_stat  (rq_stat),
        .o_head  (head)
    );

    assign o_out_valid = rq_stat.not_empty;
    assign o_out_word  = head.out_word;
    assign o_word_kind = head.word_kind;
    assign o_last      = head.last;
    assign o_status    = head.status;

`ifndef SYNTHESIS
    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_stat.count <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue over depth");

    // kept segments are a subset of the counted ones
    a_kept_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.segments_kept <= r_state.segments_seen)
        else $error("segments kept exceeds segments seen");

    // failure status only on a lone final checksum word
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_word_kind == KIND_CHECKSUM) && o_last)
        else $error("failure status on a non-checksum result");

    // a start item wipes the segment bookkeeping
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && (i_mode == MODE_START)) |=>
            (r_state.segments_seen == '0) && !r_state.too_many && (r_state.running_sum == '0))
        else $error("start item left stale state");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for boot_image_section_framer_core
// depends on bisf_pkg and the core; predicts every image word and checks them in order

module tb_top;
    import bisf_pkg::*;

    // block sizes, passed to the core so the prediction uses the same values
    localparam int SECTION_BYTES_MAX = 32768;
    localparam int VECTOR_END        = 256;
    localparam int SEGMENT_LIMIT     = 16;
    localparam int SIG_LOW           = 67;
    localparam int SIG_HIGH          = 89;

    // usable section size: whole words, never below one word
    localparam logic [31:0] SECTION_CAP = (SECTION_BYTES_MAX & ~3) < 4 ? 32'd4 :
                                          32'(SECTION_BYTES_MAX & ~3);

    localparam int  SETTLE_CYCLES    = 4;     // wait after the last predicted word has come out
    localparam int  LONG_HOLD_CYCLES = 300;   // far longer than the queue can absorb
    localparam int  RANDOM_ITEMS     = 100;
    localparam int  SPLIT_WORDS      = 6;
    localparam int  PRINT_CAP        = 100;
    localparam int  TIMEOUT_NS       = 8_000_000;

    // clock and reset
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // register writes
    logic        i_cfg_we    = 1'b0;
    t_cfg_idx    i_cfg_index = CFG_IMAGE_CONTROL;
    logic [7:0]  i_cfg_data  = '0;

    // input channel
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    t_mode       i_mode           = MODE_START;
    logic [31:0] i_seg_address    = '0;
    logic [31:0] i_seg_mem_bytes  = '0;
    logic [31:0] i_seg_file_bytes = '0;
    logic [31:0] i_data_word      = '0;
    logic [31:0] i_entry_point    = '0;

    // output channel
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_out_word;
    t_kind       o_word_kind;
    logic        o_last;
    t_status     o_status;

    // predictor copy of the framer and its registers
    t_state      framer_state;
    t_cfg        shadow_cfg;
    t_result     expected_words[$];

    int          mismatch_count = 0;
    int          items_sent     = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          hold_request   = 1'b0;

    boot_image_section_framer_core #(
        .MAX_SECTION_BYTES (SECTION_BYTES_MAX),
        .VECTOR_AREA_END   (VECTOR_END),
        .MAX_SEGMENTS      (SEGMENT_LIMIT),
        .SIGNATURE_LOW     (SIG_LOW),
        .SIGNATURE_HIGH    (SIG_HIGH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_seg_address    (i_seg_address),
        .i_seg_mem_bytes  (i_seg_mem_bytes),
        .i_seg_file_bytes (i_seg_file_bytes),
        .i_data_word      (i_data_word),
        .i_entry_point    (i_entry_point),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_word       (o_out_word),
        .o_word_kind      (o_word_kind),
        .o_last           (o_last),
        .o_status         (o_status)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // round a byte count up to whole words, saturating at the last word
    function automatic logic [31:0] round_to_words(logic [31:0] n);
        logic [32:0] r;
        r = ({1'b0, n} + 33'd3) & ~33'd3;
        return (r > 33'hFFFF_FFFC) ? 32'hFFFF_FFFC : r[31:0];
    endfunction

    function automatic void expect_word(logic [31:0] word, t_kind kind, logic last,
                                        t_status status);
        t_result r;
        r.out_word  = word;
        r.word_kind = kind;
        r.last      = last;
        r.status    = status;
        expected_words.push_back(r);
    endfunction

    // whatever is left of the open segment is abandoned
    function automatic void drop_open_segment();
        framer_state.section_address    = '0;
        framer_state.segment_bytes_left = '0;
        framer_state.section_bytes_left = '0;
        framer_state.file_bytes_left    = '0;
        framer_state.skip_bytes_left    = '0;
    endfunction

    // advance the framer by one accepted item and queue the words it must produce
    function automatic void frame_item(t_item it);
        logic [31:0] addr;
        logic [31:0] mem;
        logic [31:0] file;
        logic [31:0] skip;
        logic [31:0] word;
        logic [31:0] chunk;
        case (it.mode)
            MODE_START: begin
                framer_state = '0;
                expect_word({shadow_cfg.image_kind, shadow_cfg.image_control,
                             8'(SIG_HIGH), 8'(SIG_LOW)}, KIND_HEADER, 1'b1, ST_OK);
            end
            MODE_SEGMENT: begin
                addr = it.seg_address;
                mem  = it.seg_mem_bytes;
                file = (it.seg_file_bytes > mem) ? mem : it.seg_file_bytes;
                skip = 32'(VECTOR_END) - addr;
                drop_open_segment();
                if (framer_state.too_many || framer_state.segments_seen >= SEGMENT_LIMIT) begin
                    framer_state.too_many = 1'b1;
                end else begin
                    framer_state.segments_seen = framer_state.segments_seen + 5'd1;
                    if (!shadow_cfg.retain_vectors && addr < VECTOR_END && skip >= mem) begin
                        // vector area swallows the whole segment
                        framer_state.skip_bytes_left = round_to_words(mem);
                    end else begin
                        if (!shadow_cfg.retain_vectors && addr < VECTOR_END) begin
                            file = (file > skip) ? file - skip : '0;
                            mem  = mem - skip;
                            addr = 32'(VECTOR_END);
                            framer_state.skip_bytes_left = skip;
                        end
                        framer_state.segments_kept      = framer_state.segments_kept + 5'd1;
                        framer_state.section_address    = addr;
                        framer_state.segment_bytes_left = round_to_words(mem);
                        framer_state.file_bytes_left    = file;
                    end
                end
            end
            MODE_DATA: begin
                word = it.data_word;
                if (framer_state.skip_bytes_left != 0) begin
                    // a word partly in the skipped span goes whole
                    framer_state.skip_bytes_left = (framer_state.skip_bytes_left > 4) ?
                                                   framer_state.skip_bytes_left - 4 : '0;
                end else if (framer_state.segment_bytes_left != 0) begin
                    if (framer_state.section_bytes_left == 0) begin
                        chunk = (framer_state.segment_bytes_left > SECTION_CAP) ?
                                SECTION_CAP : framer_state.segment_bytes_left;
                        expect_word(chunk >> 2, KIND_SEC_LEN, 1'b0, ST_OK);
                        expect_word(framer_state.section_address, KIND_SEC_ADDR, 1'b0, ST_OK);
                        framer_state.section_bytes_left = chunk;
                    end
                    if (framer_state.file_bytes_left >= 4) begin
                        framer_state.file_bytes_left -= 4;
                    end else begin
                        // zero fill past the end of the file
                        word = (framer_state.file_bytes_left == 0) ? '0 :
                               word & ((32'd1 << (8 * framer_state.file_bytes_left[1:0])) - 1);
                        framer_state.file_bytes_left = '0;
                    end
                    framer_state.running_sum += word;
                    expect_word(word, KIND_PAYLOAD, 1'b1, ST_OK);
                    framer_state.section_bytes_left -= 4;
                    framer_state.segment_bytes_left -= 4;
                    framer_state.section_address    += 4;
                end
            end
            MODE_FINISH: begin
                drop_open_segment();
                if (framer_state.too_many) begin
                    expect_word('0, KIND_CHECKSUM, 1'b1, ST_TOO_MANY);
                end else if (framer_state.segments_kept == 0) begin
                    expect_word('0, KIND_CHECKSUM, 1'b1, ST_NO_SEG);
                end else begin
                    expect_word('0, KIND_END_LEN, 1'b0, ST_OK);
                    expect_word(it.entry_point, KIND_ENTRY, 1'b0, ST_OK);
                    expect_word(framer_state.running_sum, KIND_CHECKSUM, 1'b1, ST_OK);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // item builders, all unused fields carry random junk
    // ------------------------------------------------------------------

    function automatic t_item make_item(t_mode mode);
        t_item it;
        it.mode           = mode;
        it.seg_address    = $urandom;
        it.seg_mem_bytes  = $urandom;
        it.seg_file_bytes = $urandom;
        it.data_word      = $urandom;
        it.entry_point    = $urandom;
        return it;
    endfunction

    function automatic t_item segment_item(logic [31:0] addr, logic [31:0] mem,
                                           logic [31:0] file);
        t_item it;
        it = make_item(MODE_SEGMENT);
        it.seg_address    = addr;
        it.seg_mem_bytes  = mem;
        it.seg_file_bytes = file;
        return it;
    endfunction

    function automatic t_item data_item(logic [31:0] word);
        t_item it;
        it = make_item(MODE_DATA);
        it.data_word = word;
        return it;
    endfunction

    function automatic t_item finish_item(logic [31:0] entry);
        t_item it;
        it = make_item(MODE_FINISH);
        it.entry_point = entry;
        return it;
    endfunction

    // register values lean on the extremes
    function automatic logic [7:0] config_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // offer one item, hold it until taken, then update the prediction
    task automatic send_item(input t_item it);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= it.mode;
        i_seg_address    <= it.seg_address;
        i_seg_mem_bytes  <= it.seg_mem_bytes;
        i_seg_file_bytes <= it.seg_file_bytes;
        i_data_word      <= it.data_word;
        i_entry_point    <= it.entry_point;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        frame_item(it);
    endtask

    // stop offering and wait until every predicted word has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        // items with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register writes only while the framer is idle
    task automatic write_register(input t_cfg_idx idx, input logic [7:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_IMAGE_CONTROL:  shadow_cfg.image_control  = value;
            CFG_IMAGE_KIND:     shadow_cfg.image_kind     = value;
            CFG_RETAIN_VECTORS: shadow_cfg.retain_vectors = value[0];
            default: ;
        endcase
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial begin : out_stall_gen
        int burst;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 19);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                log_mismatch($sformatf("unexpected word %h kind %0d last %0d status %0d",
                                       o_out_word, o_word_kind, o_last, o_status));
            end else begin
                want = expected_words.pop_front();
                if (o_out_word !== want.out_word || o_word_kind !== want.word_kind ||
                    o_last !== want.last || o_status !== want.status) begin
                    log_mismatch($sformatf(
                        "got %h/%0d/%0d/%0d want %h/%0d/%0d/%0d (word/kind/last/status)",
                        o_out_word, o_word_kind, o_last, o_status,
                        want.out_word, want.word_kind, want.last, want.status));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register reset values, stray data, a fully dropped segment, empty finishes
    task automatic test_reset_values();
        send_item(make_item(MODE_START));
        send_item(data_item(32'h0000_0000));
        send_item(finish_item(32'h0000_0000));
        send_item(segment_item(32'h0000_0080, 32'd8, 32'd8));
        send_item(data_item(32'hFFFF_FFFF));
        send_item(data_item(32'hFFFF_FFFF));
        send_item(finish_item($urandom));
    endtask

    // trimming, partial word masking, rounding, zero size and size clamps
    task automatic test_vector_trim();
        write_register(CFG_IMAGE_CONTROL, 8'hFF);
        write_register(CFG_IMAGE_KIND, 8'h00);
        write_register(CFG_RETAIN_VECTORS, 8'h00);
        send_item(make_item(MODE_START));
        // two words inside the vector area, then five bytes of file past them
        send_item(segment_item(32'd248, 32'd20, 32'd13));
        repeat (5) send_item(data_item(32'hFFFF_FFFF));
        // unaligned start: the straddling word is dropped whole
        send_item(segment_item(32'h0000_00FE, 32'd8, 32'd8));
        repeat (3) send_item(data_item(32'hFFFF_FFFF));
        // empty segment leaves data stray
        send_item(segment_item(32'h0000_1000, 32'd0, 32'd0));
        send_item(data_item(32'hFFFF_FFFF));
        // rounding saturates
        send_item(segment_item(32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        repeat (2) send_item(make_item(MODE_DATA));
        // file size larger than memory size
        send_item(segment_item(32'h0000_0400, 32'd5, 32'd100));
        repeat (2) send_item(data_item(32'hFFFF_FFFF));
        send_item(finish_item(32'hFFFF_FFFF));
    endtask

    // more descriptors than allowed, and the overflow sticking past finish
    task automatic test_segment_overflow();
        write_register(CFG_RETAIN_VECTORS, 8'h01);
        send_item(make_item(MODE_START));
        send_item(segment_item(32'h0000_0000, 32'd4, 32'd4));
        send_item(make_item(MODE_DATA));
        repeat (SEGMENT_LIMIT) send_item(segment_item(32'h0000_0000, 32'd4, 32'd4));
        send_item(make_item(MODE_DATA));
        send_item(make_item(MODE_FINISH));
        send_item(make_item(MODE_FINISH));
    endtask

    // receiver holds off long enough that the core must stall its input
    task automatic test_output_hold();
        hold_request = 1'b1;
        send_item(make_item(MODE_START));
        send_item(segment_item(32'h0000_3000, 32'd256, 32'd250));
        repeat (40) send_item(make_item(MODE_DATA));
        send_item(finish_item(32'h0000_0000));
        // sender waits out every pending word before going on
        wait_drained();
    endtask

    // one well-formed image with random content, now and then broken or noisy
    task automatic send_random_image();
        int          n_seg;
        int          n_words;
        logic [31:0] addr;
        logic [31:0] mem;
        logic [31:0] file;
        send_item(make_item(MODE_START));
        n_seg = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
        for (int s = 0; s < n_seg; s++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: addr = VECTOR_END - 4 * $urandom_range(0, 10);
                3:       addr = 4 * $urandom_range(0, 63);
                4, 5:    addr = $urandom;
                6:       addr = VECTOR_END - $urandom_range(0, 13);
                default: addr = VECTOR_END + 4 * $urandom_range(0, 1000);
            endcase
            mem  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 48);
            file = ($urandom_range(0, 3) == 0) ? $urandom : mem - $urandom_range(0, 6);
            n_words = (mem > 64) ? 14 : (mem + 3) / 4;
            if (addr < VECTOR_END) n_words += (VECTOR_END - addr + 3) / 4;
            n_words += $urandom_range(0, 2);
            // cut short now and then, and keep long overflow images light
            if ($urandom_range(0, 5) == 0) n_words = $urandom_range(0, n_words);
            if (n_seg > 4) n_words = $urandom_range(0, 2);
            send_item(segment_item(addr, mem, file));
            repeat (n_words) send_item(make_item(MODE_DATA));
            if ($urandom_range(0, 11) == 0) send_item(make_item(t_mode'($urandom_range(0, 3))));
        end
        if ($urandom_range(0, 9) != 0) send_item(make_item(MODE_FINISH));
    endtask

    task automatic test_random_images();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) begin
                write_register(CFG_IMAGE_CONTROL, config_byte());
                write_register(CFG_IMAGE_KIND, config_byte());
                write_register(CFG_RETAIN_VECTORS, 8'($urandom_range(0, 3) == 0));
            end
            send_random_image();
        end
    endtask

    // a segment longer than one section, cut short after crossing the top of the
    // address space
    task automatic test_section_split();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        write_register(CFG_RETAIN_VECTORS, 8'h01);
        send_item(make_item(MODE_START));
        send_item(segment_item(32'hFFFF_FFF0, SECTION_CAP + 8, SECTION_CAP + 2));
        repeat (SPLIT_WORDS) send_item(make_item(MODE_DATA));
        send_item(finish_item($urandom));
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        framer_state              = '0;
        shadow_cfg.image_control  = 8'd0;
        shadow_cfg.image_kind     = 8'd176;
        shadow_cfg.retain_vectors = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_vector_trim();
        test_segment_overflow();
        test_output_hold();
        test_random_images();
        test_section_split();

        wait_drained();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard stop if the core hangs
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
